[rtl/rtt_predictive_cwnd_update_macros.svh]
// Assertion macros shared by the congestion window update block.
`ifndef RTT_PREDICTIVE_CWND_UPDATE_MACROS_SVH
`define RTT_PREDICTIVE_CWND_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RPCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RPCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rpcu_pkg.sv]
// Types, codes and constants of the congestion window update block.
package rpcu_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE    = 2'd2;

  localparam logic [16:0] ALPHA_RESET     = 17'd16384;
  localparam logic [15:0] THRESHOLD_RESET = 16'd320;
  localparam logic [15:0] SEGMENT_RESET   = 16'd536;
  localparam logic [16:0] ONE_Q16         = 17'h10000;

  localparam logic [2:0] ACT_IGNORED    = 3'd0;
  localparam logic [2:0] ACT_TAKEN      = 3'd1;
  localparam logic [2:0] ACT_SLOW_START = 3'd2;
  localparam logic [2:0] ACT_REDUCED    = 3'd3;
  localparam logic [2:0] ACT_LINEAR     = 3'd4;

  // Step counts of the shared shift/add unit.
  localparam int MUL_STEPS = 17;
  localparam int DIV_STEPS = 36;
  localparam int STEP_W    = 6;

  typedef struct packed {
    logic        mode;
    logic [23:0] rtt_us;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
  } in_word_t;

  typedef struct packed {
    logic [31:0] new_cwnd;
    logic [2:0]  action;
    logic [23:0] predicted_rtt_us;
    logic [23:0] base_rtt_us;
  } out_word_t;

  typedef struct packed {
    logic [16:0] smoothing_alpha;
    logic [15:0] ratio_threshold;
    logic [15:0] segment_size;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic op_div;
  } mdu_req_t;

endpackage

[rtl/rpcu_muldiv.sv]
// Shared shift/add unit: 40x17 bit-serial multiply and 36/32 restoring divide.
`include "rtt_predictive_cwnd_update_macros.svh"

module rpcu_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  rpcu_pkg::mdu_req_t req,
  input  logic [39:0]       opa,
  input  logic [31:0]       opb,
  output logic              done,
  output logic [56:0]       prod,
  output logic [35:0]       quo
);
  import rpcu_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic              op_div_r;
  logic [STEP_W-1:0] cnt_r;
  logic [40:0]       acc_r;
  logic [35:0]       low_r;
  logic [39:0]       opnd_r;

  logic [32:0] trial;
  logic [40:0] add_a;
  logic [40:0] add_b;
  logic [41:0] sum;
  logic        no_borrow;
  logic        load;

  assign load = req.start && !busy_r;

  // One adder serves both operations; the divide subtracts by inverting and
  // carrying in.
  always_comb begin
    trial = {acc_r[31:0], low_r[35]};
    if (op_div_r) begin
      add_a = {8'b0, trial};
      add_b = ~{9'b0, opnd_r[31:0]};
    end else begin
      add_a = acc_r;
      add_b = low_r[0] ? {1'b0, opnd_r} : '0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {41'b0, op_div_r};
    no_borrow = sum[41];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_div_r <= req.op_div;
      cnt_r    <= req.op_div ? STEP_W'(DIV_STEPS - 1) : STEP_W'(MUL_STEPS - 1);
      acc_r    <= '0;
      low_r    <= req.op_div ? opa[35:0] : {19'b0, opb[16:0]};
      opnd_r   <= req.op_div ? {8'b0, opb} : opa;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (op_div_r) begin
        acc_r <= {9'b0, (no_borrow ? sum[31:0] : trial[31:0])};
        low_r <= {low_r[34:0], no_borrow};
      end else begin
        acc_r <= {1'b0, sum[40:1]};
        low_r <= {19'b0, sum[0], low_r[16:1]};
      end
    end
  end

  assign done = done_r;
  assign prod = {acc_r[39:0], low_r[16:0]};
  assign quo  = low_r;

  `RPCU_ASSERT_IMP(a_no_start_busy, clk, rst_n, req.start, !busy_r, "start while unit busy")
  `RPCU_ASSERT_IMP(a_rem_below_div, clk, rst_n, busy_r && op_div_r, acc_r[31:0] < opnd_r[31:0], "remainder not below divisor")
  `RPCU_ASSERT_IMP(a_mul_acc_fits, clk, rst_n, busy_r && !op_div_r, !acc_r[40], "multiply accumulator overflow")
  `RPCU_ASSERT_NXT(a_done_ends_busy, clk, rst_n, busy_r && cnt_r == '0, done_r && !busy_r, "unit did not finish")

endmodule

[rtl/rpcu_seq.sv]
// Sequencer: RTT state, decision logic and operand steering for the shared unit.
`include "rtt_predictive_cwnd_update_macros.svh"

module rpcu_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  rpcu_pkg::cfg_t     cfg,
  input  logic               in_valid,
  input  rpcu_pkg::in_word_t in_data,
  output logic               idle,
  output logic               res_valid,
  output rpcu_pkg::out_word_t res,
  input  logic               res_ack,
  output rpcu_pkg::mdu_req_t mdu_req,
  output logic [39:0]        mdu_opa,
  output logic [31:0]        mdu_opb,
  input  logic               mdu_done,
  input  logic [56:0]        mdu_prod,
  input  logic [35:0]        mdu_quo
);
  import rpcu_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_A  = 3'd1;
  localparam logic [2:0] S_MUL_B  = 3'd2;
  localparam logic [2:0] S_LIMIT  = 3'd3;
  localparam logic [2:0] S_REDUCE = 3'd4;
  localparam logic [2:0] S_SQ     = 3'd5;
  localparam logic [2:0] S_LINDIV = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]  state_r,    state_nxt;
  logic        launch_r,   launch_nxt;
  in_word_t    item_r,     item_nxt;
  logic [39:0] pred_r,     pred_nxt;
  logic [23:0] base_r,     base_nxt;
  logic [40:0] t1_r,       t1_nxt;
  logic [31:0] res_cwnd_r, res_cwnd_nxt;
  logic [2:0]  act_r,      act_nxt;
  logic [2:0]  step_r,     step_nxt;

  logic [16:0] alpha_sat;
  logic [16:0] alpha_rest;
  logic [32:0] ss_sum;
  logic [32:0] lin_sum;
  logic [41:0] ewma_sum;
  logic [31:0] lin_div;
  logic [4:0]  ten_q_lo;
  logic [4:0]  rem_lo;
  logic [1:0]  ceil_adj;

  assign alpha_sat  = (cfg.smoothing_alpha > ONE_Q16) ? ONE_Q16 : cfg.smoothing_alpha;
  assign alpha_rest = ONE_Q16 - alpha_sat;
  assign ss_sum     = {1'b0, in_data.cwnd} + {17'b0, cfg.segment_size};
  assign lin_sum    = {1'b0, item_r.cwnd} + {1'b0, mdu_quo[31:0]};
  assign ewma_sum   = {1'b0, t1_r} + {1'b0, mdu_prod[56:16]};
  assign lin_div    = (item_r.cwnd == '0) ? 32'd1 : item_r.cwnd;

  // The cut computes cwnd - ceil(cwnd/10). The shift/add estimate of the
  // tenth is low by at most one, so the remainder left is below 20 and its
  // low five bits are enough to fix the estimate and to round it up.
  assign ten_q_lo = {t1_r[4:3], 3'b0} + {t1_r[6:3], 1'b0};
  assign rem_lo   = item_r.cwnd[4:0] - ten_q_lo;
  assign ceil_adj = {1'b0, rem_lo >= 5'd10} + {1'b0, rem_lo != 5'd0 && rem_lo != 5'd10};

  // Operands for the shared unit follow the state that waits on it.
  always_comb begin
    mdu_opa = '0;
    mdu_opb = '0;
    case (state_r)
      S_MUL_A: begin
        mdu_opa = {16'b0, item_r.rtt_us};
        mdu_opb = {15'b0, alpha_sat};
      end
      S_MUL_B: begin
        mdu_opa = pred_r;
        mdu_opb = {15'b0, alpha_rest};
      end
      S_LIMIT: begin
        mdu_opa = {16'b0, base_r};
        mdu_opb = {16'b0, cfg.ratio_threshold};
      end
      S_SQ: begin
        mdu_opa = {24'b0, cfg.segment_size};
        mdu_opb = {16'b0, cfg.segment_size};
      end
      S_LINDIV: begin
        mdu_opa = {8'b0, t1_r[31:0]};
        mdu_opb = lin_div;
      end
      default: begin
        mdu_opa = '0;
        mdu_opb = '0;
      end
    endcase
  end

  assign mdu_req.start  = launch_r;
  assign mdu_req.op_div = (state_r == S_LINDIV);

  always_comb begin
    state_nxt    = state_r;
    launch_nxt   = 1'b0;
    item_nxt     = item_r;
    pred_nxt     = pred_r;
    base_nxt     = base_r;
    t1_nxt       = t1_r;
    res_cwnd_nxt = res_cwnd_r;
    act_nxt      = act_r;
    step_nxt     = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_data;
          res_cwnd_nxt = in_data.cwnd;
          if (!in_data.mode) begin
            if (in_data.rtt_us == '0) begin
              act_nxt   = ACT_IGNORED;
              state_nxt = S_DONE;
            end else begin
              act_nxt = ACT_TAKEN;
              if (base_r == '0 || in_data.rtt_us < base_r) begin
                base_nxt = in_data.rtt_us;
              end
              // The first sample loads the prediction without smoothing.
              if (pred_r == '0) begin
                pred_nxt  = {in_data.rtt_us, 16'b0};
                state_nxt = S_DONE;
              end else begin
                state_nxt  = S_MUL_A;
                launch_nxt = 1'b1;
              end
            end
          end else if (in_data.cwnd < in_data.ssthresh) begin
            act_nxt      = ACT_SLOW_START;
            res_cwnd_nxt = ss_sum[32] ? '1 : ss_sum[31:0];
            state_nxt    = S_DONE;
          end else if (pred_r != '0 && base_r != '0) begin
            state_nxt  = S_LIMIT;
            launch_nxt = 1'b1;
          end else begin
            state_nxt  = S_SQ;
            launch_nxt = 1'b1;
          end
        end
      end
      S_MUL_A: begin
        if (mdu_done) begin
          t1_nxt     = mdu_prod[40:0];
          state_nxt  = S_MUL_B;
          launch_nxt = 1'b1;
        end
      end
      S_MUL_B: begin
        if (mdu_done) begin
          pred_nxt  = ewma_sum[39:0];
          state_nxt = S_DONE;
        end
      end
      S_LIMIT: begin
        if (mdu_done) begin
          // Reduce when predicted exceeds base * threshold / 256.
          if ({8'b0, pred_r} > {mdu_prod[39:0], 8'b0}) begin
            state_nxt = S_REDUCE;
            step_nxt  = '0;
          end else begin
            state_nxt  = S_SQ;
            launch_nxt = 1'b1;
          end
        end
      end
      S_REDUCE: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0: t1_nxt = {9'b0, {1'b0, item_r.cwnd[31:1]} + {2'b0, item_r.cwnd[31:2]}};
          3'd1: t1_nxt = {9'b0, t1_r[31:0] + {4'b0, t1_r[31:4]}};
          3'd2: t1_nxt = {9'b0, t1_r[31:0] + {8'b0, t1_r[31:8]}};
          3'd3: t1_nxt = {9'b0, t1_r[31:0] + {16'b0, t1_r[31:16]}};
          3'd4: t1_nxt = {9'b0, {3'b0, t1_r[31:3]} + {30'b0, ceil_adj}};
          default: begin
            act_nxt      = ACT_REDUCED;
            res_cwnd_nxt = item_r.cwnd - t1_r[31:0];
            state_nxt    = S_DONE;
          end
        endcase
      end
      S_SQ: begin
        if (mdu_done) begin
          t1_nxt     = {9'b0, mdu_prod[31:0]};
          state_nxt  = S_LINDIV;
          launch_nxt = 1'b1;
        end
      end
      S_LINDIV: begin
        if (mdu_done) begin
          act_nxt      = ACT_LINEAR;
          res_cwnd_nxt = lin_sum[32] ? '1 : lin_sum[31:0];
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      launch_r <= 1'b0;
      pred_r   <= '0;
      base_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
      pred_r   <= pred_nxt;
      base_r   <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    t1_r       <= t1_nxt;
    res_cwnd_r <= res_cwnd_nxt;
    act_r      <= act_nxt;
    step_r     <= step_nxt;
  end

  assign idle                 = (state_r == S_IDLE);
  assign res_valid            = (state_r == S_DONE);
  assign res.new_cwnd         = res_cwnd_r;
  assign res.action           = act_r;
  assign res.predicted_rtt_us = pred_r[39:16];
  assign res.base_rtt_us      = base_r;

  `RPCU_ASSERT_IMP(a_state_paired, clk, rst_n, 1'b1,
                   (pred_r != '0) == (base_r != '0), "prediction and base RTT out of step")
  `RPCU_ASSERT_IMP(a_sample_echo, clk, rst_n, res_valid && !item_r.mode,
                   res_cwnd_r == item_r.cwnd, "sample word changed the window")
  `RPCU_ASSERT_IMP(a_reduce_shrinks, clk, rst_n, res_valid && act_r == ACT_REDUCED,
                   res_cwnd_r <= item_r.cwnd, "reduced window grew")
  `RPCU_ASSERT_IMP(a_launch_waits, clk, rst_n, launch_r,
                   !idle && !res_valid, "unit launched outside a wait state")

endmodule

[rtl/rtt_predictive_cwnd_update.sv]
// Top level: configuration registers, sequencer, shared unit and output register.
//
// Input words (mode, rtt_us, cwnd, ssthresh) arrive on in_valid/in_data and
// are taken at an edge where in_valid is high and in_stall is low. Mode 0
// words are RTT samples that update the base and predicted RTT; mode 1 words
// ask for a window update. Each input word gives exactly one output word on
// out_valid/out_data, taken at an edge where out_valid is high and out_stall
// is low.
// Words that need no arithmetic (an ignored sample, a first sample or slow
// start) go straight to the done state. An EWMA update runs two multiplies
// on the shared unit, a window cut a ratio multiply and shift/add steps for
// the tenth, and linear growth a square multiply and a divide, after the
// ratio multiply when RTT state exists. The block works on one word at a
// time; in_stall stays high while the sequencer is busy.
// The output register frees the sequencer: a finished word waits there while
// out_stall is high, and the next input word is already accepted. A second
// finished word waits in the sequencer until the register drains.
// Synchronous active-low reset clears the RTT state (no sample, no
// prediction) and restores the configuration defaults. cfg_we writes
// register cfg_index at any edge; write only while the block is idle.
module rtt_predictive_cwnd_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rpcu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpcu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rpcu_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rpcu_pkg::out_word_t                 out_data
);
  import rpcu_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_word_t out_data_r;

  logic      seq_idle;
  logic      res_valid;
  out_word_t res;
  logic      res_ack;
  mdu_req_t  mdu_req;
  logic [39:0] mdu_opa;
  logic [31:0] mdu_opb;
  logic      mdu_done;
  logic [56:0] mdu_prod;
  logic [35:0] mdu_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smoothing_alpha <= ALPHA_RESET;
      cfg_r.ratio_threshold <= THRESHOLD_RESET;
      cfg_r.segment_size    <= SEGMENT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SMOOTHING_ALPHA: cfg_r.smoothing_alpha <= cfg_wdata;
        CFG_RATIO_THRESHOLD: cfg_r.ratio_threshold <= cfg_wdata[15:0];
        CFG_SEGMENT_SIZE:    cfg_r.segment_size    <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  rpcu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ack   (res_ack),
    .mdu_req   (mdu_req),
    .mdu_opa   (mdu_opa),
    .mdu_opb   (mdu_opb),
    .mdu_done  (mdu_done),
    .mdu_prod  (mdu_prod),
    .mdu_quo   (mdu_quo)
  );

  rpcu_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (mdu_opa),
    .opb   (mdu_opb),
    .done  (mdu_done),
    .prod  (mdu_prod),
    .quo   (mdu_quo)
  );

  assign in_stall = !seq_idle;

  // The output register loads a finished result whenever it is empty or being drained.
  assign res_ack = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
